// ----- hdl/v3n_pkg.sv -----
// Shared types and constants for the 3D vector normalization core.
// Used by v3n_sqrt_cell, v3n_div_cell and vector3_normalize_core.
package v3n_pkg;

   localparam int COMP_W = 32;
   localparam int SUM_W  = 2 * COMP_W;
   localparam int REM_W  = COMP_W + 1;
   localparam int NCOMP  = 3;

   typedef struct packed {
      logic signed [COMP_W-1:0] comp_x;
      logic signed [COMP_W-1:0] comp_y;
      logic signed [COMP_W-1:0] comp_z;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] unit_x;
      logic signed [COMP_W-1:0] unit_y;
      logic signed [COMP_W-1:0] unit_z;
      logic        [COMP_W-1:0] length;
      logic                     zero_vector;
   } rsp_type;

   // State handed along the square root chain.
   typedef struct packed {
      logic                          valid;
      logic [NCOMP-1:0]              neg;
      logic [NCOMP-1:0][COMP_W-1:0]  mag_abs;
      logic [REM_W-1:0]              rem;
      logic [COMP_W-1:0]             root;
      logic [SUM_W-1:0]              rad;
   } sqrt_lane_type;

   // State handed along the divider chain; quotients travel beside it.
   typedef struct packed {
      logic                          valid;
      logic                          zero;
      logic [NCOMP-1:0]              neg;
      logic [COMP_W-1:0]             mag;
      logic [NCOMP-1:0][REM_W-1:0]   rem;
   } div_lane_type;

endpackage

// ----- hdl/v3n_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit per cell.
// Depends on v3n_pkg.
module v3n_sqrt_cell
   import v3n_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  sqrt_lane_type lane_in,
   output sqrt_lane_type lane_out
);

   sqrt_lane_type             lane_ff;
   sqrt_lane_type             lane_in_next;
   logic [REM_W+1:0]          rem_t;
   logic [REM_W+1:0]          trial;

   always_comb begin
      rem_t        = {lane_in.rem, lane_in.rad[SUM_W-1 -: 2]};
      trial        = {1'b0, lane_in.root, 2'b01};
      lane_in_next = lane_in;
      lane_in_next.rad = {lane_in.rad[SUM_W-3:0], 2'b00};
      if (rem_t >= trial) begin
         lane_in_next.rem  = REM_W'(rem_t - trial);
         lane_in_next.root = {lane_in.root[COMP_W-2:0], 1'b1};
      end else begin
         lane_in_next.rem  = REM_W'(rem_t);
         lane_in_next.root = {lane_in.root[COMP_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in_next;
      end
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end
   end

   assign lane_out = lane_ff;

endmodule

// ----- hdl/v3n_div_cell.sv -----
// One cell of the divider chain: one quotient bit for each of the three lanes.
// Depends on v3n_pkg.
module v3n_div_cell
   import v3n_pkg::*;
#(
   parameter int QUO_W = 31
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  div_lane_type                lane_in,
   input  logic [NCOMP-1:0][QUO_W-1:0] quo_in,
   output div_lane_type                lane_out,
   output logic [NCOMP-1:0][QUO_W-1:0] quo_out
);

   div_lane_type                lane_ff;
   div_lane_type                lane_in_next;
   logic [NCOMP-1:0][QUO_W-1:0] quo_ff;
   logic [NCOMP-1:0][QUO_W-1:0] quo_in_next;
   logic [REM_W-1:0]            rem_sub;

   always_comb begin
      lane_in_next = lane_in;
      quo_in_next  = quo_in;
      rem_sub      = '0;
      for (int i = 0; i < NCOMP; i++) begin
         // compare, subtract, then shift the partial remainder for the next bit
         if (lane_in.rem[i] >= {1'b0, lane_in.mag}) begin
            rem_sub        = lane_in.rem[i] - {1'b0, lane_in.mag};
            quo_in_next[i] = {quo_in[i][QUO_W-2:0], 1'b1};
         end else begin
            rem_sub        = lane_in.rem[i];
            quo_in_next[i] = {quo_in[i][QUO_W-2:0], 1'b0};
         end
         lane_in_next.rem[i] = {rem_sub[REM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in_next;
         quo_ff  <= quo_in_next;
      end
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end
   end

   assign lane_out = lane_ff;
   assign quo_out  = quo_ff;

endmodule

// ----- hdl/vector3_normalize_core.sv -----
// vector3_normalize_core: normalizes one signed Q16.16 3D vector per item and
// returns the three Q1.30 unit components, the truncated Q16.16 magnitude and
// a zero-vector flag (unit components and length are then zero). One item is
// accepted every cycle unless the pipeline holds; each item passes the input,
// square and sum registers, the 32-cell square root chain, the OUT_FRAC_BITS + 1
// cell divider chain and the output register. The whole pipeline holds while a
// result waits under rsp_stall.
// Depends on v3n_pkg, v3n_sqrt_cell and v3n_div_cell.
module vector3_normalize_core
   import v3n_pkg::*;
#(
   parameter int OUT_FRAC_BITS = 30
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int QUO_W = OUT_FRAC_BITS + 1;
   localparam int NROOT = COMP_W;

   logic advance;

   // input stage: absolute values and signs
   logic                         in_valid_ff;
   logic [NCOMP-1:0]             in_neg_ff;
   logic [NCOMP-1:0][COMP_W-1:0] in_abs_ff;
   logic [NCOMP-1:0][COMP_W-1:0] comp_in;

   // square stage
   logic                         sq_valid_ff;
   logic [NCOMP-1:0]             sq_neg_ff;
   logic [NCOMP-1:0][COMP_W-1:0] sq_abs_ff;
   logic [NCOMP-1:0][SUM_W-1:0]  sq_ff;

   // sum stage feeds the root chain
   sqrt_lane_type                sqrt_chain [0:NROOT];
   div_lane_type                 div_chain  [0:QUO_W];
   logic [NCOMP-1:0][QUO_W-1:0]  quo_chain  [0:QUO_W];
   sqrt_lane_type                sum_ff;

   // output register
   logic                         rsp_valid_ff;
   rsp_type                      rsp_data_ff;
   rsp_type                      rsp_data_in;
   logic [NCOMP-1:0][COMP_W-1:0] unit_in;
   logic [QUO_W-1:0]             quo_sat;

   // Hold everything while the output register is full and stalled.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   assign comp_in[0] = req_data.comp_x;
   assign comp_in[1] = req_data.comp_y;
   assign comp_in[2] = req_data.comp_z;

   always_ff @(posedge clock) begin
      if (advance) begin
         in_valid_ff <= req_valid;
         for (int i = 0; i < NCOMP; i++) begin
            in_neg_ff[i] <= comp_in[i][COMP_W-1];
            in_abs_ff[i] <= comp_in[i][COMP_W-1] ? (~comp_in[i] + COMP_W'(1)) : comp_in[i];
         end
         sq_valid_ff <= in_valid_ff;
         sq_neg_ff   <= in_neg_ff;
         sq_abs_ff   <= in_abs_ff;
         for (int i = 0; i < NCOMP; i++) begin
            sq_ff[i] <= SUM_W'(in_abs_ff[i]) * SUM_W'(in_abs_ff[i]);
         end
         // three squares of at most 2^62 each never overflow 64 bits
         sum_ff.valid   <= sq_valid_ff;
         sum_ff.neg     <= sq_neg_ff;
         sum_ff.mag_abs <= sq_abs_ff;
         sum_ff.rem     <= '0;
         sum_ff.root    <= '0;
         sum_ff.rad     <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
      if (reset) begin
         in_valid_ff  <= 1'b0;
         sq_valid_ff  <= 1'b0;
         sum_ff.valid <= 1'b0;
      end
   end

   assign sqrt_chain[0] = sum_ff;

   for (genvar k = 0; k < NROOT; k++) begin : g_sqrt
      v3n_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .lane_in  (sqrt_chain[k]),
         .lane_out (sqrt_chain[k+1])
      );
   end

   // Hand the root over to the divider chain; remainder starts at |comp|.
   always_comb begin
      div_chain[0].valid = sqrt_chain[NROOT].valid;
      div_chain[0].zero  = (sqrt_chain[NROOT].root == '0);
      div_chain[0].neg   = sqrt_chain[NROOT].neg;
      div_chain[0].mag   = sqrt_chain[NROOT].root;
      for (int i = 0; i < NCOMP; i++) begin
         div_chain[0].rem[i] = {1'b0, sqrt_chain[NROOT].mag_abs[i]};
      end
   end
   assign quo_chain[0] = '0;

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      v3n_div_cell #(.QUO_W(QUO_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .lane_in  (div_chain[k]),
         .quo_in   (quo_chain[k]),
         .lane_out (div_chain[k+1]),
         .quo_out  (quo_chain[k+1])
      );
   end

   // Clamp to one, restore sign, drop everything for the zero vector.
   always_comb begin
      quo_sat = '0;
      for (int i = 0; i < NCOMP; i++) begin
         quo_sat = (quo_chain[QUO_W][i] > (QUO_W'(1) << OUT_FRAC_BITS))
                 ? (QUO_W'(1) << OUT_FRAC_BITS) : quo_chain[QUO_W][i];
         if (div_chain[QUO_W].zero) begin
            unit_in[i] = '0;
         end else if (div_chain[QUO_W].neg[i]) begin
            unit_in[i] = COMP_W'(0) - COMP_W'(quo_sat);
         end else begin
            unit_in[i] = COMP_W'(quo_sat);
         end
      end
      rsp_data_in.unit_x      = unit_in[0];
      rsp_data_in.unit_y      = unit_in[1];
      rsp_data_in.unit_z      = unit_in[2];
      rsp_data_in.length      = div_chain[QUO_W].mag;
      rsp_data_in.zero_vector = div_chain[QUO_W].zero;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_valid_ff <= div_chain[QUO_W].valid;
         rsp_data_ff  <= rsp_data_in;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Zero vector gives zero length and zero components.
   a_zero_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_vector |->
         rsp_data.length == '0 && rsp_data.unit_x == '0 &&
         rsp_data.unit_y == '0 && rsp_data.unit_z == '0)
      else $error("zero vector result not cleared");

   // A zero magnitude never comes without the zero flag.
   a_len_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.zero_vector |-> rsp_data.length != '0)
      else $error("zero length without zero flag");

   // The x unit component stays within plus or minus one.
   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         $signed(rsp_data.unit_x) <= $signed(COMP_W'(1) << OUT_FRAC_BITS) &&
         $signed(rsp_data.unit_x) >= -$signed(COMP_W'(1) << OUT_FRAC_BITS))
      else $error("unit_x out of range");

   // A stall freezes the root at the end of the root chain.
   a_chain_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(sqrt_chain[NROOT].root))
      else $error("root chain moved under stall");

endmodule

// ----- sim/tb_vector3_normalize_core.sv -----
`timescale 1ns / 100ps
// Testbench for vector3_normalize_core: directed table plus random vectors,
// checked against an in-bench fixed-point normalizer. Depends on v3n_pkg and vector3_normalize_core.
module tb_vector3_normalize_core;
   import v3n_pkg::*;

   localparam int OUT_FRAC = 30;
   localparam int LATENCY = OUT_FRAC + 37;
   localparam int RANDOM_ITEMS = 650;
   localparam longint CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   vector3_normalize_core #(.OUT_FRAC_BITS(OUT_FRAC)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // One row of the directed table: an input vector and, where obvious,
   // the typed-in result (has_fixed set).
   typedef struct {
      req_type vec;
      bit      has_fixed;
      rsp_type fixed;
   } table_row_type;

   rsp_type   pending_units[$];
   int        error_count;
   longint    cycle_count;
   int        random_sent;
   int        accepted_count;
   bit        long_holdoff;
   bit        stim_done;
   table_row_type vector_table[$];

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Bit-serial floor square root of a 64-bit sum of squares.
   function automatic logic [31:0] floor_root(logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem = v;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem && bitv != 0) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res[31:0];
   endfunction

   function automatic logic [31:0] unit_component(logic signed [31:0] c,
                                                  logic [31:0] mag);
      logic [63:0] a;
      logic [63:0] q;
      a = c[31] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
      q = (a << OUT_FRAC) / {32'd0, mag};
      if (q > (64'd1 << OUT_FRAC)) q = 64'd1 << OUT_FRAC;
      if (c[31]) q = 64'd0 - q;
      return q[31:0];
   endfunction

   function automatic rsp_type normalize_vector(req_type v);
      rsp_type r;
      logic [63:0] ax, ay, az;
      logic [31:0] mag;
      ax = v.comp_x[31] ? (64'h1_0000_0000 - {32'd0, v.comp_x}) : {32'd0, v.comp_x};
      ay = v.comp_y[31] ? (64'h1_0000_0000 - {32'd0, v.comp_y}) : {32'd0, v.comp_y};
      az = v.comp_z[31] ? (64'h1_0000_0000 - {32'd0, v.comp_z}) : {32'd0, v.comp_z};
      mag = floor_root(ax * ax + ay * ay + az * az);
      r = '0;
      if (mag == 0) begin
         r.zero_vector = 1'b1;
      end else begin
         r.unit_x = unit_component(v.comp_x, mag);
         r.unit_y = unit_component(v.comp_y, mag);
         r.unit_z = unit_component(v.comp_z, mag);
         r.length = mag;
      end
      return r;
   endfunction

   function automatic req_type make_vec(int x, int y, int z);
      req_type v;
      v.comp_x = x;
      v.comp_y = y;
      v.comp_z = z;
      return v;
   endfunction

   function automatic rsp_type make_rsp(int ux, int uy, int uz, int unsigned len, bit zv);
      rsp_type r;
      r.unit_x = ux;
      r.unit_y = uy;
      r.unit_z = uz;
      r.length = len;
      r.zero_vector = zv;
      return r;
   endfunction

   // Draw a component biased toward the extremes and small magnitudes.
   function automatic logic [31:0] random_comp();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return $urandom_range(0, 3) - 1;
         4: return $urandom_range(0, 131072) - 65536;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_row(req_type v, bit fixed_ok, rsp_type r);
      table_row_type row;
      row.vec = v;
      row.has_fixed = fixed_ok;
      row.fixed = r;
      vector_table.push_back(row);
   endtask

   // Offer one item and hold it until accepted.
   task automatic send_vec(req_type v);
      req_valid <= 1'b1;
      req_data  <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_sender();
      int gap;
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stimulus: directed table first, then random vectors.
   initial begin
      rsp_type none;
      req_type v;
      none = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      stim_done = 0;
      random_sent = 0;
      // zero vector: flag set, everything else zero
      add_row(make_vec(0, 0, 0), 1, make_rsp(0, 0, 0, 0, 1));
      // unit axes: length equals the component's magnitude, unit is exactly plus or minus one
      add_row(make_vec(32'h0001_0000, 0, 0), 1, make_rsp(32'h4000_0000, 0, 0, 32'h0001_0000, 0));
      add_row(make_vec(0, 32'hffff_0000, 0), 1, make_rsp(0, 32'hc000_0000, 0, 32'h0001_0000, 0));
      add_row(make_vec(0, 0, 1), 1, make_rsp(0, 0, 32'h4000_0000, 1, 0));
      add_row(make_vec(0, 0, -1), 1, make_rsp(0, 0, 32'hc000_0000, 1, 0));
      // most negative component on x and y, most positive component on z
      add_row(make_vec(32'h8000_0000, 0, 0), 1, make_rsp(32'hc000_0000, 0, 0, 32'h8000_0000, 0));
      add_row(make_vec(0, 32'h8000_0000, 0), 1, make_rsp(0, 32'hc000_0000, 0, 32'h8000_0000, 0));
      add_row(make_vec(0, 0, 32'h7fff_ffff), 1, make_rsp(0, 0, 32'h4000_0000, 32'h7fff_ffff, 0));
      // largest magnitudes, all signs
      add_row(make_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, none);
      add_row(make_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 0, none);
      add_row(make_vec(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000), 0, none);
      add_row(make_vec(1, 1, 1), 0, none);
      add_row(make_vec(-1, 1, -1), 0, none);
      add_row(make_vec(3 << 16, 4 << 16, 0), 0, none);
      add_row(make_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f), 0, none);
      add_row(make_vec(32'h0000_ffff, 32'hffff_0001, 32'h1234_5678), 0, none);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (vector_table[i]) begin
         if (vector_table[i].has_fixed &&
             vector_table[i].fixed != normalize_vector(vector_table[i].vec)) begin
            $display("%0t table row %0d disagrees with predictor", $time, i);
            error_count++;
         end
         send_vec(vector_table[i].vec);
         idle_sender();
      end
      // pause until the pipeline has drained
      req_valid <= 1'b0;
      while (pending_units.size() != 0) @(posedge clock);
      while (random_sent < RANDOM_ITEMS) begin
         v.comp_x = random_comp();
         v.comp_y = random_comp();
         v.comp_z = random_comp();
         send_vec(v);
         random_sent++;
         // run back-to-back during the long hold-off to fill the pipe
         if (!(random_sent >= 200 && random_sent < 400)) idle_sender();
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   // Record the expectation for every accepted item.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pending_units.push_back(normalize_vector(req_data));
         accepted_count++;
      end
   end

   // Receiver: random stall per item, one long hold-off mid-run.
   initial begin
      int wait_cycles;
      rsp_stall = 1'b1;
      long_holdoff = 0;
      @(negedge reset);
      forever begin
         if (!long_holdoff && random_sent >= 220) begin
            long_holdoff = 1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end
         wait_cycles = $urandom_range(0, 11);
         if ($urandom_range(0, 3) == 0) wait_cycles = 0;
         if (wait_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_units.size() == 0) begin
            $display("%0t unexpected result %h", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_units.pop_front();
            if (rsp_data.unit_x !== want.unit_x) begin
               $display("%0t unit_x exp %h got %h", $time, want.unit_x, rsp_data.unit_x);
               error_count++;
            end
            if (rsp_data.unit_y !== want.unit_y) begin
               $display("%0t unit_y exp %h got %h", $time, want.unit_y, rsp_data.unit_y);
               error_count++;
            end
            if (rsp_data.unit_z !== want.unit_z) begin
               $display("%0t unit_z exp %h got %h", $time, want.unit_z, rsp_data.unit_z);
               error_count++;
            end
            if (rsp_data.length !== want.length) begin
               $display("%0t length exp %h got %h", $time, want.length, rsp_data.length);
               error_count++;
            end
            if (rsp_data.zero_vector !== want.zero_vector) begin
               $display("%0t zero_vector exp %b got %b", $time, want.zero_vector,
                        rsp_data.zero_vector);
               error_count++;
            end
         end
      end
   end

   // Watchdog and end of run.
   initial begin
      error_count = 0;
      accepted_count = 0;
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout, %0d results outstanding", $time, pending_units.size());
            $display("vector3_normalize_core test failed");
            $finish;
         end
         if (stim_done && pending_units.size() == 0) begin
            repeat (LATENCY + 20) @(posedge clock);
            if (pending_units.size() != 0) begin
               $display("%0t %0d expectations left over", $time, pending_units.size());
               error_count++;
            end
            $display("Covered %0d vectors: zero, axis, extreme and random inputs,",
                     accepted_count);
            $display("with random stalls, one long result hold-off and a drain pause.");
            if (error_count == 0) begin
               $display("vector3_normalize_core test passed");
            end else begin
               $display("vector3_normalize_core test failed");
            end
            $finish;
         end
      end
   end

endmodule

// ----- files.f -----
hdl/v3n_pkg.sv
hdl/v3n_sqrt_cell.sv
hdl/v3n_div_cell.sv
hdl/vector3_normalize_core.sv
sim/tb_vector3_normalize_core.sv
